// ===== hw/rtl/rc_pulse_capture_scaler_assert.svh =====
// Assertion macros for the RC pulse capture scaler.
`ifndef RC_PULSE_CAPTURE_SCALER_ASSERT_SVH
`define RC_PULSE_CAPTURE_SCALER_ASSERT_SVH

// Property that must hold at every edge outside reset.
`define RCPS_ASSERT_HOLD(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle that forces a consequence in the next.
`define RCPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rcps_pkg.sv =====
// Shared types and constants of the RC pulse capture scaler.
package rcps_pkg;

   // configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 18;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH_CENTER = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH_SPAN   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANGLE_OFFSET = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANGLE_SPAN   = 3'd5;

   localparam logic [15:0]        RST_MIN_WIDTH    = 16'd500;
   localparam logic [15:0]        RST_MAX_WIDTH    = 16'd2500;
   localparam logic [15:0]        RST_WIDTH_CENTER = 16'd1500;
   localparam logic [15:0]        RST_WIDTH_SPAN   = 16'd350;
   localparam logic signed [17:0] RST_ANGLE_OFFSET = 18'sd0;
   localparam logic signed [16:0] RST_ANGLE_SPAN   = 17'sd1000;

   // edge queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = 1;
   localparam int CNT_BITS    = 2;

   // serial divider
   localparam int QUO_BITS  = 32;
   localparam int STEP_BITS = 5;

   typedef struct packed {
      logic [15:0]        min_width;
      logic [15:0]        max_width;
      logic [15:0]        width_center;
      logic [15:0]        width_span;
      logic signed [17:0] angle_offset;
      logic signed [16:0] angle_span;
   } cfg_type;

   typedef struct packed {
      logic [15:0] width_us;
      logic [31:0] good_stamp_us;
      logic        accepted;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SIGN,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

// ===== hw/rtl/rcps_front.sv =====
// Edge front end: start capture, width check, held width and good time.
module rcps_front #(
   parameter int TIME_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_pin_high,
   input  logic [31:0]                  req_stamp_us,
   input  rcps_pkg::cfg_type            cfg,
   input  rcps_pkg::queue_status_type   q_status,
   output logic                         push,
   output rcps_pkg::entry_type          push_entry
);
   import rcps_pkg::*;

   localparam int STAMP_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;

   logic [STAMP_BITS-1:0] stamp_m;
   logic [TIME_BITS-1:0]  stamp_t;
   logic [TIME_BITS-1:0]  width_t;
   logic [TIME_BITS-1:0]  rise_time_ff, rise_time_in;
   logic [15:0]           held_width_ff, held_width_in;
   logic [31:0]           good_time_ff, good_time_in;
   logic                  fire, hi_zero, in_range, start_seen, take;

   assign stamp_m = req_stamp_us[STAMP_BITS-1:0];
   assign stamp_t = TIME_BITS'(stamp_m);
   assign width_t = stamp_t - rise_time_ff;

   // widths beyond 16 bits can never fall inside the bounds
   if (TIME_BITS > 16) begin : g_wide
      assign hi_zero = (width_t[TIME_BITS-1:16] == '0);
   end else begin : g_narrow
      assign hi_zero = 1'b1;
   end

   always_comb begin
      req_stall  = q_status.full;
      fire       = req_valid && !req_stall;
      start_seen = (rise_time_ff != '0);
      in_range   = hi_zero && (width_t[15:0] > cfg.min_width) &&
                   (width_t[15:0] < cfg.max_width);
      take       = fire && !req_pin_high && start_seen && in_range;

      rise_time_in  = (fire && req_pin_high) ? stamp_t : rise_time_ff;
      held_width_in = take ? width_t[15:0] : held_width_ff;
      good_time_in  = take ? 32'(stamp_m) : good_time_ff;

      push                     = fire;
      push_entry.width_us      = held_width_in;
      push_entry.good_stamp_us = good_time_in;
      push_entry.accepted      = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_time_ff  <= '0;
         held_width_ff <= '0;
         good_time_ff  <= '0;
      end else begin
         rise_time_ff  <= rise_time_in;
         held_width_ff <= held_width_in;
         good_time_ff  <= good_time_in;
      end
   end

endmodule

// ===== hw/rtl/rcps_queue.sv =====
// Two-entry queue of classified edges between front and back.
module rcps_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  rcps_pkg::entry_type          push_entry,
   input  logic                         pop,
   output rcps_pkg::entry_type          pop_entry,
   output rcps_pkg::queue_status_type   q_status
);
   import rcps_pkg::*;

   entry_type             mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      q_status.empty = (count_ff == '0);
      q_status.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
      pop_entry      = mem[rd_ptr_ff];
      wr_ptr_in      = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in      = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in       = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/rcps_back.sv =====
// Angle scaler: multiply, serial divide, offset, saturate, result register.
module rcps_back (
   input  logic                         clock,
   input  logic                         reset,
   input  rcps_pkg::cfg_type            cfg,
   input  rcps_pkg::queue_status_type   q_status,
   input  rcps_pkg::entry_type          pop_entry,
   output logic                         pop,
   output logic                         back_idle,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [15:0]                  rsp_width_us,
   output logic [31:0]                  rsp_good_stamp_us,
   output logic signed [31:0]           rsp_angle,
   output logic                         rsp_accepted
);
   import rcps_pkg::*;

   localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
   localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

   back_state_type         state_ff, state_in;
   entry_type              ent_ff, ent_in;
   logic signed [33:0]     prod_ff, prod_in;
   logic                   neg_ff, neg_in;
   logic [QUO_BITS-1:0]    dvd_ff, dvd_in;
   logic [15:0]            rem_ff, rem_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   entry_type              rsp_ent_ff, rsp_ent_in;
   logic signed [31:0]     rsp_angle_ff, rsp_angle_in;

   logic signed [16:0]     diff;
   logic signed [33:0]     prod_full;
   logic [33:0]            prod_abs;
   logic [16:0]            rem_shift;
   logic [16:0]            rem_sub;
   logic                   ge;
   logic [QUO_BITS-1:0]    quo;
   logic signed [33:0]     quo_s;
   logic signed [34:0]     sum;
   logic                   out_free;

   always_comb begin
      diff      = $signed({1'b0, ent_ff.width_us}) - $signed({1'b0, cfg.width_center});
      prod_full = diff * $signed(cfg.angle_span);
      prod_abs  = prod_ff[33] ? 34'(-prod_ff) : 34'(prod_ff);

      // one restoring step per cycle
      rem_shift = {rem_ff, dvd_ff[QUO_BITS-1]};
      ge        = (rem_shift >= {1'b0, cfg.width_span});
      rem_sub   = rem_shift - {1'b0, cfg.width_span};

      // zero divisor reads as a zero quotient
      quo   = (cfg.width_span == '0) ? '0 : dvd_ff;
      quo_s = neg_ff ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
      sum   = 35'(quo_s) + 35'($signed(cfg.angle_offset));

      out_free = !rsp_valid_ff || !rsp_stall;

      state_in     = state_ff;
      ent_in       = ent_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_ent_in   = rsp_ent_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               ent_in   = pop_entry;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            prod_in  = prod_full;
            state_in = BK_SIGN;
         end
         BK_SIGN: begin
            neg_in   = prod_ff[33];
            dvd_in   = prod_abs[QUO_BITS-1:0];
            rem_in   = '0;
            step_in  = '0;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            rem_in  = ge ? rem_sub[15:0] : rem_shift[15:0];
            dvd_in  = {dvd_ff[QUO_BITS-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(QUO_BITS - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ent_in   = ent_ff;
               if (sum > SAT_MAX) begin
                  rsp_angle_in = SAT_MAX[31:0];
               end else if (sum < SAT_MIN) begin
                  rsp_angle_in = SAT_MIN[31:0];
               end else begin
                  rsp_angle_in = sum[31:0];
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff       <= ent_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      rsp_ent_ff   <= rsp_ent_in;
      rsp_angle_ff <= rsp_angle_in;
   end

   assign back_idle         = (state_ff == BK_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_width_us      = rsp_ent_ff.width_us;
   assign rsp_good_stamp_us = rsp_ent_ff.good_stamp_us;
   assign rsp_angle         = rsp_angle_ff;
   assign rsp_accepted      = rsp_ent_ff.accepted;

endmodule

// ===== hw/rtl/rc_pulse_capture_scaler.sv =====
// Top level of the RC pulse capture scaler.
//
// Measures RC receiver pulses from pin edge transactions and scales the last
// good width to an angle. Each req_ transaction is one edge: req_pin_high
// gives the new level and req_stamp_us the free-running microsecond time. A
// rising edge records its time as the pulse start (a start stamped zero means
// no start). A falling edge measures the width modulo 2^TIME_BITS from that
// start and keeps it, with the edge time, when min_width < width < max_width.
// Every edge yields exactly one rsp_ transaction: held width, last good time,
// accepted flag, and angle = (width - width_center) * angle_span / width_span
// + angle_offset, truncated toward zero and saturated to 32-bit signed (a zero
// width_span gives angle_offset). The front end takes one edge per cycle into
// a two-entry queue and stalls only when that queue is full. The scaler
// behind it takes each edge from the queue through a pop, a multiply, a sign step,
// the one-bit-per-cycle restoring divider and a finish step, and takes the next
// edge only once done with the last; the divider sets the sustained rate. A
// finished result waits in the result register while the next is already scaled.
// Configuration registers are to be written over csr_ (always ready) only while
// the block is idle, which it does not enforce; no clearing pass after reset.
module rc_pulse_capture_scaler #(
   parameter int TIME_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // edge transactions
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_pin_high,
   input  logic [31:0]                            req_stamp_us,
   // result transactions
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [15:0]                            rsp_width_us,
   output logic [31:0]                            rsp_good_stamp_us,
   output logic signed [31:0]                     rsp_angle,
   output logic                                   rsp_accepted,
   // configuration writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rcps_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rcps_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import rcps_pkg::*;

`include "rc_pulse_capture_scaler_assert.svh"

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   entry_type        push_entry, pop_entry;
   logic             push, pop, back_idle;

   // register file; indexes past the list are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_WIDTH:    cfg_in.min_width    = csr_data[15:0];
            CSR_MAX_WIDTH:    cfg_in.max_width    = csr_data[15:0];
            CSR_WIDTH_CENTER: cfg_in.width_center = csr_data[15:0];
            CSR_WIDTH_SPAN:   cfg_in.width_span   = csr_data[15:0];
            CSR_ANGLE_OFFSET: cfg_in.angle_offset = $signed(csr_data[17:0]);
            CSR_ANGLE_SPAN:   cfg_in.angle_span   = $signed(csr_data[16:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_width    <= RST_MIN_WIDTH;
         cfg_ff.max_width    <= RST_MAX_WIDTH;
         cfg_ff.width_center <= RST_WIDTH_CENTER;
         cfg_ff.width_span   <= RST_WIDTH_SPAN;
         cfg_ff.angle_offset <= RST_ANGLE_OFFSET;
         cfg_ff.angle_span   <= RST_ANGLE_SPAN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: start capture and width check, one edge per cycle unless the queue is full
   rcps_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pin_high (req_pin_high),
      .req_stamp_us (req_stamp_us),
      .cfg          (cfg_ff),
      .q_status     (q_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   // decouples the edge rate from the divider
   rcps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   // back: angle scaling and result register
   rcps_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_status          (q_status),
      .pop_entry         (pop_entry),
      .pop               (pop),
      .back_idle         (back_idle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_width_us      (rsp_width_us),
      .rsp_good_stamp_us (rsp_good_stamp_us),
      .rsp_angle         (rsp_angle),
      .rsp_accepted      (rsp_accepted)
   );

   // nothing queued, nothing in flight: no result can appear
   `RCPS_ASSERT_NEXT(a_no_phantom_rsp, clock, reset, q_status.empty && back_idle && !rsp_valid && !(req_valid && !req_stall), !rsp_valid, "result without a pending edge")
   // an accepted edge is always held in the queue the next cycle
   `RCPS_ASSERT_NEXT(a_edge_queued, clock, reset, req_valid && !req_stall, !q_status.empty, "accepted edge lost before queue")
   // a stored width is strictly above a nonnegative bound
   `RCPS_ASSERT_HOLD(a_accept_nonzero, clock, reset, !(rsp_valid && rsp_accepted) || (rsp_width_us != 16'd0), "accepted result with zero width")

endmodule
